[sv/dwc_pkg.sv]
// shared types and constants of the 3x3 depthwise convolution
package dwc_pkg;

   localparam int PIXEL_BITS  = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int PROD_BITS   = PIXEL_BITS + WEIGHT_BITS;
   localparam int PART_BITS   = PROD_BITS + 2;
   localparam int VALUE_BITS  = PIXEL_BITS + 19;
   localparam int LINE_DEPTH  = 512;
   localparam int COL_BITS    = $clog2(LINE_DEPTH);
   localparam int MAX_ROWS    = 4096;
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int WIDTH_BITS  = 10;
   localparam int HEIGHT_BITS = 13;
   localparam int KTAPS       = 3;
   localparam int KROW_BITS   = KTAPS * WEIGHT_BITS;
   localparam int NPROD       = KTAPS * KTAPS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MIN_SIDE    = 3;
   localparam int FIRST_OUT   = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PADDED_WIDTH  = 3'd0,
      CSR_PADDED_HEIGHT = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MIDDLE = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [PIXEL_BITS-1:0] pixel;
      logic                         frame_start;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         row_last;
      logic                         frame_last;
   } rsp_type;

   // row 0 is the top kernel row
   typedef logic [KTAPS-1:0][KROW_BITS-1:0] kernel_type;

   typedef struct packed {
      logic                emit;
      logic                row_last;
      logic                frame_last;
      logic [COL_BITS-1:0] col;
   } tag_type;

   typedef struct packed {
      logic [NPROD-1:0][PROD_BITS-1:0] prod;
      logic                            row_last;
      logic                            frame_last;
   } prd_type;

endpackage

[sv/dwc_seq.sv]
// configuration registers and raster position counters
module dwc_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dwc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dwc_pkg::KROW_BITS-1:0]         csr_wdata,
   input  logic                                  req_fire,
   input  logic                                  frame_start,
   output dwc_pkg::tag_type                      tag,
   output dwc_pkg::kernel_type                   kernel
);
   import dwc_pkg::*;

   logic [WIDTH_BITS-1:0]  pw_ff;
   logic [HEIGHT_BITS-1:0] ph_ff;
   kernel_type             kern_ff;
   logic [COL_BITS-1:0]    col_ff, col_in, col;
   logic [ROW_BITS-1:0]    row_ff, row_in, row;
   logic [COL_BITS-1:0]    w_last;
   logic [ROW_BITS-1:0]    h_last;

   assign csr_ready = 1'b1;
   assign kernel    = kern_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff   <= WIDTH_BITS'(MIN_SIDE);
         ph_ff   <= HEIGHT_BITS'(MIN_SIDE);
         kern_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PADDED_WIDTH:  pw_ff      <= csr_wdata[WIDTH_BITS-1:0];
            CSR_PADDED_HEIGHT: ph_ff      <= csr_wdata[HEIGHT_BITS-1:0];
            CSR_KERNEL_TOP:    kern_ff[0] <= csr_wdata;
            CSR_KERNEL_MIDDLE: kern_ff[1] <= csr_wdata;
            CSR_KERNEL_BOTTOM: kern_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped geometry, kept as last column and last row
   always_comb begin
      if (pw_ff < WIDTH_BITS'(MIN_SIDE)) begin
         w_last = COL_BITS'(MIN_SIDE - 1);
      end else if (pw_ff > WIDTH_BITS'(LINE_DEPTH)) begin
         w_last = COL_BITS'(LINE_DEPTH - 1);
      end else begin
         w_last = COL_BITS'(pw_ff - WIDTH_BITS'(1));
      end
      if (ph_ff < HEIGHT_BITS'(MIN_SIDE)) begin
         h_last = ROW_BITS'(MIN_SIDE - 1);
      end else if (ph_ff > HEIGHT_BITS'(MAX_ROWS)) begin
         h_last = ROW_BITS'(MAX_ROWS - 1);
      end else begin
         h_last = ROW_BITS'(ph_ff - HEIGHT_BITS'(1));
      end
   end

   always_comb begin
      col = frame_start ? '0 : col_ff;
      row = frame_start ? '0 : row_ff;
      tag.col        = col;
      tag.emit       = (row >= ROW_BITS'(FIRST_OUT)) && (col >= COL_BITS'(FIRST_OUT));
      tag.row_last   = col >= w_last;
      tag.frame_last = tag.row_last && (row >= h_last);
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (tag.row_last) begin
            col_in = '0;
            row_in = tag.frame_last ? '0 : row + ROW_BITS'(1);
         end else begin
            col_in = col + COL_BITS'(1);
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[sv/dwc_line.sv]
// line store, 3x3 window and the nine products
module dwc_line (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_fire,
   output logic                         req_ready,
   input  logic [dwc_pkg::PIXEL_BITS-1:0] pixel,
   input  dwc_pkg::tag_type             tag,
   input  dwc_pkg::kernel_type          kernel,
   output logic                         prd_valid,
   input  logic                         prd_ready,
   output dwc_pkg::prd_type             prd
);
   import dwc_pkg::*;

   localparam int PAIR_BITS = 2 * PIXEL_BITS;

   // each entry holds {row r-2, row r-1} of one column
   logic [PAIR_BITS-1:0]  mem [LINE_DEPTH];
   logic [PAIR_BITS-1:0]  rd_ff, fwd_ff, pair;
   logic                  byp_ff, byp_in;
   logic                  s1_valid_ff, s1_valid_in;
   tag_type               s1_tag_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic                  s1_go, s2_ready;
   logic [KTAPS-1:0][PIXEL_BITS-1:0]      cur;
   logic [KTAPS-1:0][1:0][PIXEL_BITS-1:0] win_ff;
   logic [NPROD-1:0][PROD_BITS-1:0]       prod;
   logic                  prd_valid_ff, prd_valid_in;
   prd_type               prd_ff;
   logic [PIXEL_BITS-1:0] px;
   logic [WEIGHT_BITS-1:0] wt;

   assign s2_ready  = !prd_valid_ff || prd_ready;
   assign s1_go     = s1_valid_ff && (!s1_tag_ff.emit || s2_ready);
   assign req_ready = !s1_valid_ff || s1_go;

   // a column read while the previous transaction writes it takes the new pair
   assign byp_in = s1_valid_ff && (tag.col == s1_tag_ff.col);
   assign pair   = byp_ff ? fwd_ff : rd_ff;
   assign cur[0] = pair[PAIR_BITS-1:PIXEL_BITS];
   assign cur[1] = pair[PIXEL_BITS-1:0];
   assign cur[2] = s1_pixel_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= mem[tag.col];
      end
      if (s1_go) begin
         mem[s1_tag_ff.col] <= {cur[1], s1_pixel_ff};
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_tag_ff   <= tag;
         s1_pixel_ff <= pixel;
         byp_ff      <= byp_in;
         fwd_ff      <= {cur[1], s1_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_go) begin
         for (int k = 0; k < KTAPS; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= cur[k];
         end
      end
   end

   // column 0 of a kernel row is the oldest window column
   always_comb begin
      px = '0;
      wt = '0;
      for (int k = 0; k < KTAPS; k++) begin
         for (int j = 0; j < KTAPS; j++) begin
            px = (j < 2) ? win_ff[k][j] : cur[k];
            wt = kernel[k][j*WEIGHT_BITS +: WEIGHT_BITS];
            prod[k*KTAPS + j] = PROD_BITS'($signed(px) * $signed(wt));
         end
      end
   end

   assign prd_valid_in = s2_ready ? (s1_valid_ff && s1_tag_ff.emit) : prd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         prd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         prd_valid_ff <= prd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         prd_ff.prod       <= prod;
         prd_ff.row_last   <= s1_tag_ff.row_last;
         prd_ff.frame_last <= s1_tag_ff.frame_last;
      end
   end

   assign prd_valid = prd_valid_ff;
   assign prd       = prd_ff;

endmodule

[sv/dwc_sum.sv]
// two-level adder tree and the result register
module dwc_sum (
   input  logic              clock,
   input  logic              reset,
   input  logic              prd_valid,
   output logic              prd_ready,
   input  dwc_pkg::prd_type  prd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dwc_pkg::rsp_type  rsp_data
);
   import dwc_pkg::*;

   logic [KTAPS-1:0][PART_BITS-1:0] part, part_ff;
   logic                            s3_valid_ff, s3_valid_in;
   logic                            s3_row_last_ff, s3_frame_last_ff;
   logic                            s3_ready, out_ready;
   logic                            out_valid_ff, out_valid_in;
   rsp_type                         out_ff;
   logic signed [VALUE_BITS-1:0]    total;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign prd_ready = s3_ready;

   // one partial sum per kernel row
   always_comb begin
      for (int k = 0; k < KTAPS; k++) begin
         part[k] = PART_BITS'($signed(prd.prod[k*KTAPS]))
                 + PART_BITS'($signed(prd.prod[k*KTAPS + 1]))
                 + PART_BITS'($signed(prd.prod[k*KTAPS + 2]));
      end
   end

   assign total = VALUE_BITS'($signed(part_ff[0])) + VALUE_BITS'($signed(part_ff[1]))
                + VALUE_BITS'($signed(part_ff[2]));

   assign s3_valid_in  = s3_ready ? prd_valid : s3_valid_ff;
   assign out_valid_in = out_ready ? s3_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         part_ff          <= part;
         s3_row_last_ff   <= prd.row_last;
         s3_frame_last_ff <= prd.frame_last;
      end
      if (out_ready) begin
         out_ff.value      <= total;
         out_ff.row_last   <= s3_row_last_ff;
         out_ff.frame_last <= s3_frame_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[sv/depthwise_conv3x3_stride1.sv]
// top level of the 3x3 stride-1 depthwise convolution
//
//   channel   direction   payload                            transaction when
//   req_      in          pixel, frame_start                 req_valid & req_ready
//   rsp_      out         value, row_last, frame_last        rsp_valid & rsp_ready
//   csr_      in          csr_index, csr_wdata (48 bits)     csr_valid & csr_ready
//
// one pixel per cycle unless rsp_ stalls; each result is registered in turn by the line
// read, products, row sums and final sum stages, the last being the output register
// the line store is one 512 x 32 memory read and written once per pixel
// synchronous reset clears counters, window and valid bits; the line store is not cleared
// a stalled rsp_ fills the internal stages before req_ready drops
module depthwise_conv3x3_stride1 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dwc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dwc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dwc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dwc_pkg::KROW_BITS-1:0]      csr_wdata
);
   import dwc_pkg::*;

   logic       req_fire;
   tag_type    tag;
   kernel_type kernel;
   logic       prd_valid, prd_ready;
   prd_type    prd;

   assign req_fire = req_valid && req_ready;

   dwc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_fire    (req_fire),
      .frame_start (req_data.frame_start),
      .tag         (tag),
      .kernel      (kernel)
   );

   dwc_line u_line (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_ready),
      .pixel     (req_data.pixel),
      .tag       (tag),
      .kernel    (kernel),
      .prd_valid (prd_valid),
      .prd_ready (prd_ready),
      .prd       (prd)
   );

   dwc_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .prd_valid (prd_valid),
      .prd_ready (prd_ready),
      .prd       (prd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
